// ===== rtl/segment_endpoint_snapper_macros.svh =====
// ----------------------------------------------------------------------------
// segment endpoint snapper assertion macros
// concurrent checks clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SEGMENT_ENDPOINT_SNAPPER_MACROS_SVH
`define SEGMENT_ENDPOINT_SNAPPER_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define SEP_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// expression must never be true out of reset
`define SEP_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error(msg);

`else

`define SEP_ASSERT(name, prop, msg)

`define SEP_NEVER(name, expr, msg)

`endif

`endif

// ===== rtl/sep_pkg.sv =====
// ----------------------------------------------------------------------------
// sep_pkg
// shared types and constants of the segment endpoint snapper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sep_pkg;

	localparam int GAP_BITS = 8;
	localparam logic [GAP_BITS-1:0] GAP_RESET = 8'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic i_clr;
		logic i_inc;
		logic j_init;
		logic j_inc;
		logic k_clr;
		logic k_inc;
		logic rd_a;
		logic rd_b;
		logic rd_e;
		logic cap_a;
		logic diff_en;
		logic sq_en;
		logic decide;
		logic emit;
		logic list_clr;
	} cmd_t;

	// loop status from the datapath to the controller
	typedef struct packed {
		logic few;
		logic i_last;
		logic j_last;
		logic e_last;
	} stat_t;

endpackage

// ===== rtl/sep_ctrl.sv =====
// ----------------------------------------------------------------------------
// sep_ctrl
// sequencer for load, pair pass and emission of the segment list
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_endpoint_snapper_macros.svh"

module sep_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           last_segment,
	input  sep_pkg::stat_t stat,
	output sep_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           cfg_ready
);
	import sep_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_RD_A,
		S_CAP_A,
		S_RD_B,
		S_DIFF,
		S_SQ,
		S_DECIDE,
		S_EMIT_RD,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_segment) begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				cmd.i_clr = 1'b1;
				cmd.k_clr = 1'b1;
				state_d = stat.few ? S_EMIT_RD : S_RD_A;
			end
			S_RD_A: begin
				cmd.rd_a = 1'b1;
				cmd.j_init = 1'b1;
				state_d = S_CAP_A;
			end
			// segment i arrives while segment j is requested
			S_CAP_A: begin
				cmd.cap_a = 1'b1;
				cmd.rd_b = 1'b1;
				state_d = S_DIFF;
			end
			S_RD_B: begin
				cmd.rd_b = 1'b1;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff_en = 1'b1;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.sq_en = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (!stat.j_last) begin
					cmd.j_inc = 1'b1;
					state_d = S_RD_B;
				end else if (!stat.i_last) begin
					cmd.i_inc = 1'b1;
					state_d = S_RD_A;
				end else begin
					state_d = S_EMIT_RD;
				end
			end
			S_EMIT_RD: begin
				cmd.rd_e = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				cmd.k_inc = 1'b1;
				if (stat.e_last) begin
					cmd.list_clr = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_EMIT_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	`SEP_ASSERT(a_decide_after_sq, state_q == S_DECIDE |-> $past(state_q) == S_SQ, "decide without square stage")
	`SEP_ASSERT(a_last_starts_pass, start && !busy && last_segment |=> busy, "last request did not start pass")

endmodule

// ===== rtl/sep_datapath.sv =====
// ----------------------------------------------------------------------------
// sep_datapath
// segment store, loop counters, distance pipeline and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_endpoint_snapper_macros.svh"

module sep_datapath #(
	parameter int MAX_SEGMENTS = 64,
	parameter int COORD_BITS   = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sep_pkg::cmd_t                cmd,
	output sep_pkg::stat_t               stat,
	input  logic                         cfg_we,
	input  logic [sep_pkg::GAP_BITS-1:0] cfg_data,
	input  logic [COORD_BITS-1:0]        start_x,
	input  logic [COORD_BITS-1:0]        start_y,
	input  logic [COORD_BITS-1:0]        end_x,
	input  logic [COORD_BITS-1:0]        end_y,
	output logic                         result_valid,
	output logic [COORD_BITS-1:0]        out_start_x,
	output logic [COORD_BITS-1:0]        out_start_y,
	output logic [COORD_BITS-1:0]        out_end_x,
	output logic [COORD_BITS-1:0]        out_end_y,
	output logic                         final_result,
	output logic                         any_snapped,
	output logic                         overflowed
);
	import sep_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int SW = 4 * CB;
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int DW = 2 * CB + 1;

	function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] p, input logic [CB-1:0] q);
		return (p > q) ? (p - q) : (q - p);
	endfunction

	// segment word is {sx, sy, ex, ey}
	logic [SW-1:0]   mem [MAX_SEGMENTS];
	logic [SW-1:0]   rd_q;
	logic [SW-1:0]   a_q;
	logic [SW-1:0]   b_s1;
	logic [SW-1:0]   b_s2;
	logic [CB-1:0]   d_s1 [8];
	logic [2*CB-1:0] sq_s2 [8];

	logic [CW-1:0] count_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] k_q;
	logic          snap_q;
	logic          ovf_q;
	logic [GAP_BITS-1:0]   gap_q;
	logic [2*GAP_BITS-1:0] g2_q;

	logic full;
	logic mem_we;
	logic [IW-1:0] mem_waddr;
	logic [SW-1:0] mem_wdata;
	logic rd_en;
	logic [IW-1:0] rd_addr;

	logic [CB-1:0] a_sx, a_sy, a_ex, a_ey;
	logic [CB-1:0] b_sx, b_sy, b_ex, b_ey;
	logic [CB-1:0] p_sx, p_sy, p_ex, p_ey;
	logic [DW-1:0] ss, es, se, ee, g2w;
	logic n_ss, n_es, n_se, n_ee;
	logic [SW-1:0] wr_seg;
	logic snap_now;

	logic          valid_q;
	logic [SW-1:0] out_q;
	logic          final_q;
	logic          snapped_q;
	logic          ovf_out_q;

	assign full = (count_q == CW'(MAX_SEGMENTS));

	assign stat.few    = (count_q < CW'(2));
	assign stat.i_last = ((CW'(i_q) + CW'(2)) == count_q);
	assign stat.j_last = ((CW'(j_q) + CW'(1)) == count_q);
	assign stat.e_last = ((CW'(k_q) + CW'(1)) == count_q);

	// configuration and squared gap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_RESET;
		end else if (cfg_we) begin
			gap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		g2_q <= gap_q * gap_q;
	end

	// list state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			snap_q  <= 1'b0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.list_clr) begin
				count_q <= '0;
				snap_q  <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				if (cmd.load) begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				if (cmd.decide && snap_now) begin
					snap_q <= 1'b1;
				end
			end
			if (cmd.i_clr) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + IW'(1);
			end
			if (cmd.j_init) begin
				j_q <= i_q + IW'(1);
			end else if (cmd.j_inc) begin
				j_q <= j_q + IW'(1);
			end
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + IW'(1);
			end
		end
	end

	// segment store, one write and one registered read port
	assign mem_we    = (cmd.load && !full) || cmd.decide;
	assign mem_waddr = cmd.decide ? j_q : count_q[IW-1:0];
	assign mem_wdata = cmd.decide ? wr_seg : {start_x, start_y, end_x, end_y};
	assign rd_en     = cmd.rd_a || cmd.rd_b || cmd.rd_e;
	assign rd_addr   = cmd.rd_a ? i_q : (cmd.rd_b ? j_q : k_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			a_q <= rd_q;
		end
	end

	assign a_sx = a_q[4*CB-1:3*CB];
	assign a_sy = a_q[3*CB-1:2*CB];
	assign a_ex = a_q[2*CB-1:CB];
	assign a_ey = a_q[CB-1:0];
	assign b_sx = rd_q[4*CB-1:3*CB];
	assign b_sy = rd_q[3*CB-1:2*CB];
	assign b_ex = rd_q[2*CB-1:CB];
	assign b_ey = rd_q[CB-1:0];

	// stage 1: coordinate differences of the four endpoint pairings
	always_ff @(posedge clk) begin
		if (cmd.diff_en) begin
			b_s1    <= rd_q;
			d_s1[0] <= abs_diff(a_sx, b_sx);
			d_s1[1] <= abs_diff(a_sy, b_sy);
			d_s1[2] <= abs_diff(a_ex, b_sx);
			d_s1[3] <= abs_diff(a_ey, b_sy);
			d_s1[4] <= abs_diff(a_sx, b_ex);
			d_s1[5] <= abs_diff(a_sy, b_ey);
			d_s1[6] <= abs_diff(a_ex, b_ex);
			d_s1[7] <= abs_diff(a_ey, b_ey);
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (cmd.sq_en) begin
			b_s2 <= b_s1;
			for (int n = 0; n < 8; n++) begin
				sq_s2[n] <= d_s1[n] * d_s1[n];
			end
		end
	end

	assign p_sx = b_s2[4*CB-1:3*CB];
	assign p_sy = b_s2[3*CB-1:2*CB];
	assign p_ex = b_s2[2*CB-1:CB];
	assign p_ey = b_s2[CB-1:0];

	// stage 3: sums, gap compare and the snap choice
	always_comb begin
		ss  = DW'(sq_s2[0]) + DW'(sq_s2[1]);
		es  = DW'(sq_s2[2]) + DW'(sq_s2[3]);
		se  = DW'(sq_s2[4]) + DW'(sq_s2[5]);
		ee  = DW'(sq_s2[6]) + DW'(sq_s2[7]);
		g2w = DW'(g2_q);
		n_ss = (ss < g2w);
		n_es = (es < g2w);
		n_se = (se < g2w);
		n_ee = (ee < g2w);
		wr_seg = b_s2;
		snap_now = 1'b0;
		if ((n_ss && n_ee) || (n_se && n_es)) begin
			wr_seg = a_q;
		end else if (n_ss && (ss != '0)) begin
			wr_seg = {a_sx, a_sy, p_ex, p_ey};
			snap_now = 1'b1;
		end else if (n_es && (es != '0)) begin
			wr_seg = {a_ex, a_ey, p_ex, p_ey};
			snap_now = 1'b1;
		end else if (n_se && (se != '0)) begin
			wr_seg = {p_sx, p_sy, a_sx, a_sy};
			snap_now = 1'b1;
		end else if (n_ee && (ee != '0)) begin
			wr_seg = {p_sx, p_sy, a_ex, a_ey};
			snap_now = 1'b1;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q     <= rd_q;
			final_q   <= stat.e_last;
			snapped_q <= snap_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign result_valid = valid_q;
	assign out_start_x  = out_q[4*CB-1:3*CB];
	assign out_start_y  = out_q[3*CB-1:2*CB];
	assign out_end_x    = out_q[2*CB-1:CB];
	assign out_end_y    = out_q[CB-1:0];
	assign final_result = final_q;
	assign any_snapped  = snapped_q;
	assign overflowed   = ovf_out_q;

	`SEP_NEVER(a_count_range, count_q > CW'(MAX_SEGMENTS), "segment count beyond capacity")
	`SEP_ASSERT(a_strobe_spaced, valid_q |=> !valid_q, "results on adjacent cycles")
	`SEP_ASSERT(a_final_clears, valid_q && final_q |-> count_q == '0, "list not cleared after final result")

endmodule

// ===== rtl/segment_endpoint_snapper.sv =====
// ----------------------------------------------------------------------------
// segment_endpoint_snapper
// collects a segment list, snaps near endpoints pairwise, emits the list
// ----------------------------------------------------------------------------
// Segments load one per cycle while busy is low; the request flagged with
// last_segment starts the pass. Every pair of stored segments then goes
// through a read of segment j from the single read port of the store, the
// difference stage, the square stage, and compare and write-back; each new
// segment i costs one extra read, and each result takes a read and an
// output state. Results appear on every other cycle while result_valid is
// high and must be taken at once; there is no back pressure. The snap gap
// is written through cfg_valid and cfg_data while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_endpoint_snapper #(
	parameter int MAX_SEGMENTS = 64,
	parameter int COORD_BITS   = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [COORD_BITS-1:0]        start_x,
	input  logic [COORD_BITS-1:0]        start_y,
	input  logic [COORD_BITS-1:0]        end_x,
	input  logic [COORD_BITS-1:0]        end_y,
	input  logic                         last_segment,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sep_pkg::GAP_BITS-1:0] cfg_data,
	output logic                         result_valid,
	output logic [COORD_BITS-1:0]        out_start_x,
	output logic [COORD_BITS-1:0]        out_start_y,
	output logic [COORD_BITS-1:0]        out_end_x,
	output logic [COORD_BITS-1:0]        out_end_y,
	output logic                         final_result,
	output logic                         any_snapped,
	output logic                         overflowed
);
	import sep_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  cfg_we;

	assign cfg_we = cfg_valid && cfg_ready;

	sep_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.last_segment (last_segment),
		.stat         (stat),
		.cmd          (cmd),
		.busy         (busy),
		.cfg_ready    (cfg_ready)
	);

	sep_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.COORD_BITS   (COORD_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.result_valid (result_valid),
		.out_start_x  (out_start_x),
		.out_start_y  (out_start_y),
		.out_end_x    (out_end_x),
		.out_end_y    (out_end_y),
		.final_result (final_result),
		.any_snapped  (any_snapped),
		.overflowed   (overflowed)
	);

endmodule

// ===== sim/segment_endpoint_snapper_test.sv =====
// ----------------------------------------------------------------------------
// segment_endpoint_snapper_test
// loads segment lists through start/busy, predicts the snapped lists and
// checks every emitted segment in order against the prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_endpoint_snapper_test;

	import sep_pkg::*;

	localparam int MAX_SEGMENTS = 64;
	localparam int COORD_BITS   = 12;
	localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
	localparam int SETTLE_CYCLES = 40;
	localparam longint RUN_LIMIT_NS = 5_000_000;

	typedef struct {
		bit [COORD_BITS-1:0] sx;
		bit [COORD_BITS-1:0] sy;
		bit [COORD_BITS-1:0] ex;
		bit [COORD_BITS-1:0] ey;
	} segment_t;

	typedef struct {
		segment_t seg;
		bit last_flag;
		bit snapped;
		bit dropped;
	} list_result_t;

	// holds the list being loaded, runs the pair pass, and queues the output
	class snap_ledger;
		segment_t list_store[MAX_SEGMENTS];
		int unsigned list_len;
		bit snap_seen;
		bit drop_seen;
		bit [GAP_BITS-1:0] gap;
		list_result_t due_segments[$];
		int unsigned mismatches;
		int unsigned checked;

		function new();
			list_len = 0;
			snap_seen = 1'b0;
			drop_seen = 1'b0;
			gap = GAP_RESET;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_gap(bit [GAP_BITS-1:0] g);
			gap = g;
		endfunction

		function int unsigned pending();
			return due_segments.size();
		endfunction

		function bit [31:0] sq_dist(bit [COORD_BITS-1:0] ax, bit [COORD_BITS-1:0] ay,
				bit [COORD_BITS-1:0] bx, bit [COORD_BITS-1:0] by);
			bit [31:0] dx;
			bit [31:0] dy;
			dx = (ax > bx) ? 32'(ax - bx) : 32'(bx - ax);
			dy = (ay > by) ? 32'(ay - by) : 32'(by - ay);
			return dx * dx + dy * dy;
		endfunction

		function void snap_pass();
			segment_t a;
			segment_t b;
			bit [31:0] g2;
			bit [31:0] ss;
			bit [31:0] es;
			bit [31:0] se;
			bit [31:0] ee;
			g2 = 32'(gap) * 32'(gap);
			for (int i = 0; i < list_len; i++) begin
				a = list_store[i];
				for (int j = i + 1; j < list_len; j++) begin
					b = list_store[j];
					ss = sq_dist(a.sx, a.sy, b.sx, b.sy);
					es = sq_dist(a.ex, a.ey, b.sx, b.sy);
					se = sq_dist(a.sx, a.sy, b.ex, b.ey);
					ee = sq_dist(a.ex, a.ey, b.ex, b.ey);
					if ((ss < g2 && ee < g2) || (se < g2 && es < g2)) begin
						list_store[j] = a;
					end else if (ss < g2 && ss != 0) begin
						b.sx = a.sx;
						b.sy = a.sy;
						list_store[j] = b;
						snap_seen = 1'b1;
					end else if (es < g2 && es != 0) begin
						b.sx = a.ex;
						b.sy = a.ey;
						list_store[j] = b;
						snap_seen = 1'b1;
					end else if (se < g2 && se != 0) begin
						b.ex = a.sx;
						b.ey = a.sy;
						list_store[j] = b;
						snap_seen = 1'b1;
					end else if (ee < g2 && ee != 0) begin
						b.ex = a.ex;
						b.ey = a.ey;
						list_store[j] = b;
						snap_seen = 1'b1;
					end
				end
			end
		endfunction

		function void note_request(segment_t s, bit last);
			list_result_t r;
			if (list_len < MAX_SEGMENTS) begin
				list_store[list_len] = s;
				list_len++;
			end else begin
				drop_seen = 1'b1;
			end
			if (last) begin
				snap_pass();
				for (int k = 0; k < list_len; k++) begin
					r.seg = list_store[k];
					r.last_flag = (k + 1 == list_len);
					r.snapped = snap_seen;
					r.dropped = drop_seen;
					due_segments = {due_segments, r};
				end
				list_len = 0;
				snap_seen = 1'b0;
				drop_seen = 1'b0;
			end
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch on result %0d: %s", $realtime, checked, msg);
			mismatches++;
		endtask

		task compare_field(string field, int got, int want);
			if (got != want)
				report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
		endtask

		task check_result(list_result_t got);
			list_result_t want;
			if (due_segments.size() == 0) begin
				report_mismatch("segment emitted with none pending");
			end else begin
				want = due_segments.pop_front();
				compare_field("out_start_x", int'(got.seg.sx), int'(want.seg.sx));
				compare_field("out_start_y", int'(got.seg.sy), int'(want.seg.sy));
				compare_field("out_end_x", int'(got.seg.ex), int'(want.seg.ex));
				compare_field("out_end_y", int'(got.seg.ey), int'(want.seg.ey));
				compare_field("final_result", int'(got.last_flag), int'(want.last_flag));
				compare_field("any_snapped", int'(got.snapped), int'(want.snapped));
				compare_field("overflowed", int'(got.dropped), int'(want.dropped));
			end
			checked++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [COORD_BITS-1:0] start_x = '0;
	logic [COORD_BITS-1:0] start_y = '0;
	logic [COORD_BITS-1:0] end_x = '0;
	logic [COORD_BITS-1:0] end_y = '0;
	logic last_segment = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [GAP_BITS-1:0] cfg_data = '0;
	logic result_valid;
	logic [COORD_BITS-1:0] out_start_x;
	logic [COORD_BITS-1:0] out_start_y;
	logic [COORD_BITS-1:0] out_end_x;
	logic [COORD_BITS-1:0] out_end_y;
	logic final_result;
	logic any_snapped;
	logic overflowed;

	snap_ledger ledger = new();
	int sender_idle_pct = 0;

	segment_endpoint_snapper #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.COORD_BITS(COORD_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.last_segment(last_segment),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.out_start_x(out_start_x),
		.out_start_y(out_start_y),
		.out_end_x(out_end_x),
		.out_end_y(out_end_y),
		.final_result(final_result),
		.any_snapped(any_snapped),
		.overflowed(overflowed)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin : result_monitor
		list_result_t got;
		if (arst_n && result_valid) begin
			got.seg.sx = out_start_x;
			got.seg.sy = out_start_y;
			got.seg.ex = out_end_x;
			got.seg.ey = out_end_y;
			got.last_flag = final_result;
			got.snapped = any_snapped;
			got.dropped = overflowed;
			ledger.check_result(got);
		end
	end

	function automatic segment_t make_segment(int sx, int sy, int ex, int ey);
		segment_t s;
		s.sx = sx[COORD_BITS-1:0];
		s.sy = sy[COORD_BITS-1:0];
		s.ex = ex[COORD_BITS-1:0];
		s.ey = ey[COORD_BITS-1:0];
		return s;
	endfunction

	function automatic int wobble(int center, int spread);
		int v;
		v = center + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v;
	endfunction

	// anchors often sit on the border so clamped coordinates show up
	function automatic int pick_anchor();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 2)
			return 0;
		if (roll < 4)
			return COORD_MAX;
		return $urandom_range(0, COORD_MAX);
	endfunction

	task automatic send_segment(input segment_t s, input bit last);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < sender_idle_pct);
		end
		start <= 1'b1;
		start_x <= s.sx;
		start_y <= s.sy;
		end_x <= s.ex;
		end_y <= s.ey;
		last_segment <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		ledger.note_request(s, last);
	endtask

	// sender holds off until every pending segment has come out
	task automatic drain();
		start <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_gap(input bit [GAP_BITS-1:0] g);
		// wait before the gap write; the list is cleared as the final result is emitted
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= g;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		ledger.set_gap(g);
	endtask

	task automatic send_cluster_list(input int count, input int spread);
		int px;
		int py;
		int qx;
		int qy;
		int roll;
		segment_t s;
		segment_t prev;
		px = pick_anchor();
		py = pick_anchor();
		qx = pick_anchor();
		qy = pick_anchor();
		prev = make_segment(px, py, qx, qy);
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				s = make_segment($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
					$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
			end else if (roll < 24) begin
				s = prev;
			end else if (roll < 40) begin
				// one end near an anchor, the other anywhere
				s = make_segment(wobble(px, spread), wobble(py, spread),
					$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
			end else begin
				s = make_segment(wobble(px, spread), wobble(py, spread),
					wobble(qx, spread), wobble(qy, spread));
			end
			if ($urandom_range(0, 1))
				s = make_segment(int'(s.ex), int'(s.ey), int'(s.sx), int'(s.sy));
			prev = s;
			send_segment(s, k == count - 1);
		end
	endtask

	initial begin : stimulus
		bit [GAP_BITS-1:0] g;
		int sent;
		int n;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gap: single segment list at the coordinate extremes, then a copy
		send_segment(make_segment(0, 0, COORD_MAX, COORD_MAX), 1'b1);
		send_segment(make_segment(COORD_MAX, 0, 0, COORD_MAX), 1'b0);
		send_segment(make_segment(COORD_MAX - 1, 0, 0, COORD_MAX), 1'b1);
		drain();

		// each of the four endpoint snaps, a reversed copy, an exact copy,
		// and a shared start at zero distance that stays as it is
		write_gap(8'd10);
		sender_idle_pct = 36;
		send_segment(make_segment(1000, 1000, 2000, 2000), 1'b0);
		send_segment(make_segment(1003, 1000, 3000, 3000), 1'b0);
		send_segment(make_segment(2000, 2004, 500, 500), 1'b0);
		send_segment(make_segment(3500, 3500, 1002, 1001), 1'b0);
		send_segment(make_segment(300, 300, 2001, 2002), 1'b0);
		send_segment(make_segment(2002, 2001, 1001, 1000), 1'b0);
		send_segment(make_segment(1000, 1000, 2000, 2000), 1'b0);
		send_segment(make_segment(1000, 1000, 50, 50), 1'b1);
		drain();

		// zero gap leaves everything alone
		write_gap(8'd0);
		sender_idle_pct = 0;
		send_segment(make_segment(5, 5, 9, 9), 1'b0);
		send_segment(make_segment(5, 5, 9, 9), 1'b0);
		send_segment(make_segment(6, 5, 9, 9), 1'b1);
		drain();

		// widest gap, with a distance exactly at the gap which is not near
		write_gap(8'd255);
		sender_idle_pct = 74;
		send_segment(make_segment(0, 0, COORD_MAX, COORD_MAX), 1'b0);
		send_segment(make_segment(254, 0, 0, COORD_MAX), 1'b0);
		send_segment(make_segment(180, 180, COORD_MAX, 0), 1'b0);
		send_segment(make_segment(COORD_MAX, COORD_MAX, 255, 0), 1'b1);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: g = 8'd1;
				1: g = 8'd255;
				2: g = 8'd0;
				default: g = 8'($urandom_range(2, 40));
			endcase
			write_gap(g);
			case (ph % 3)
				0: sender_idle_pct = 0;
				1: sender_idle_pct = 74;
				default: sender_idle_pct = 36;
			endcase
			sent = 0;
			while (sent < 28) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
				send_cluster_list(n, $urandom_range(0, int'(g) + 3));
				sent += n;
			end
			drain();
		end

		// full store, then two requests that get dropped, the final one among them
		write_gap(8'd24);
		sender_idle_pct = 36;
		send_cluster_list(MAX_SEGMENTS + 2, 30);
		drain();

		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (ledger.mismatches == 0 && ledger.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== segment_endpoint_snapper.f =====
+incdir+rtl
rtl/sep_pkg.sv
rtl/sep_ctrl.sv
rtl/sep_datapath.sv
rtl/segment_endpoint_snapper.sv
sim/segment_endpoint_snapper_test.sv
